// ===== design/tled_pkg.sv =====
// Shared types and request codes for the two-level event dispatcher.
package tled_pkg;

    localparam int PORT_W = 10;
    localparam int IRQ_W  = 8;
    localparam int REQ_W  = 3;

    localparam logic [REQ_W-1:0] REQ_RAISE    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_MASK     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNMASK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ACK      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_BIND     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_UNBIND   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_DISPATCH = 3'd6;

    typedef struct packed {
        logic             bound;
        logic [IRQ_W-1:0] irq;
    } map_entry_t;

endpackage

// ===== design/tled_grp_mem.sv =====
// Per-group pending and mask bitmap memory with row valid bits for reset values.
module tled_grp_mem
    import tled_pkg::*;
#(
    parameter int WORD_BITS  = 32,
    parameter int NUM_GROUPS = 32,
    parameter int GA_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [GA_W-1:0]      rd_addr,
    output logic [WORD_BITS-1:0] rd_pend,
    output logic [WORD_BITS-1:0] rd_mask,
    input  logic                 wr_en,
    input  logic [GA_W-1:0]      wr_addr,
    input  logic [WORD_BITS-1:0] wr_pend,
    input  logic [WORD_BITS-1:0] wr_mask
);

    logic [2*WORD_BITS-1:0] mem [NUM_GROUPS];
    logic [2*WORD_BITS-1:0] rd_data_reg;
    logic [NUM_GROUPS-1:0]  row_valid_reg;
    logic                   rd_valid_reg;

    // Write and read the storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_pend, wr_mask};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track rows written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // Unwritten rows read as nothing pending, all masked
    assign rd_pend = rd_valid_reg ? rd_data_reg[2*WORD_BITS-1:WORD_BITS] : '0;
    assign rd_mask = rd_valid_reg ? rd_data_reg[WORD_BITS-1:0] : '1;

endmodule

// ===== design/tled_map_mem.sv =====
// Port-to-IRQ map memory, one write and one registered read port.
module tled_map_mem
    import tled_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic       clk,
    input  logic       rd_en,
    input  logic [AW-1:0] rd_addr,
    output map_entry_t rd_data,
    input  logic       wr_en,
    input  logic [AW-1:0] wr_addr,
    input  map_entry_t wr_data
);

    map_entry_t mem [DEPTH];

    // Write and read the map
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/two_level_event_dispatch_unit.sv =====
// Two-level event channel dispatcher: pending/mask bitmaps in a group memory,
// IRQ map in a port memory, and a resumable lowest-first scan. Raise, mask,
// unmask and ack read, modify and write back a group memory row; bind and
// unbind each do a single map write. A dispatch step moves the selector into
// the scan when no groups remain, loads each remaining group row (ST_LOAD),
// then takes the lowest port of the snapshot and reads its map entry
// (ST_MAPRD), or reports the scan done. A step whose result is
// ready while the previous result still waits holds until out_ready.
// After reset the IRQ map is swept to unbound, one entry a cycle, over
// NUM_GROUPS*WORD_BITS entries (1024 by default); no item is taken meanwhile.
// A finished result sits in an output register, so the next request can be
// taken while the result waits for out_ready.
module two_level_event_dispatch_unit
    import tled_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int NUM_PORTS = 1024,
    parameter int NUM_IRQS  = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [PORT_W-1:0] port,
    input  logic [IRQ_W-1:0]  irq_number,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PORT_W-1:0] event_port,
    output logic [IRQ_W-1:0]  event_irq,
    output logic              is_bound,
    output logic              event_valid,
    output logic              scan_done
);

    localparam int GROUPS_RAW   = NUM_PORTS / WORD_BITS;
    localparam int NUM_GROUPS   = (GROUPS_RAW < WORD_BITS) ? GROUPS_RAW : WORD_BITS;
    localparam int USABLE_PORTS = NUM_GROUPS * WORD_BITS;
    localparam int GA_W         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int MA_W         = $clog2(USABLE_PORTS);
    localparam int DIV_K        = PORT_W + BIT_W + 1;
    localparam int RECIP        = ((1 << DIV_K) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W       = PORT_W + DIV_K + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RMW   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_MAPRD = 3'd5;

    // Lowest set bit of a group snapshot
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // Lowest set bit of the remaining groups
    function automatic logic [GA_W-1:0] lowest_group(input logic [NUM_GROUPS-1:0] v);
        logic [GA_W-1:0] idx;
        idx = '0;
        for (int i = NUM_GROUPS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = GA_W'(i);
            end
        end
        return idx;
    endfunction

    logic [2:0]            state_reg, state_next;
    logic [MA_W-1:0]       clr_reg, clr_next;
    logic [NUM_GROUPS-1:0] sel_reg, sel_next;
    logic                  upcall_reg, upcall_next;
    logic [NUM_GROUPS-1:0] gl_reg, gl_next;
    logic [GA_W-1:0]       gi_reg, gi_next;
    logic [WORD_BITS-1:0]  bl_reg, bl_next;
    logic                  out_valid_reg, out_valid_next;

    logic [REQ_W-1:0]      req_reg;
    logic [GA_W-1:0]       g_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic [MA_W-1:0]       scan_port_reg;
    logic [PORT_W-1:0]     event_port_reg;
    logic [IRQ_W-1:0]      event_irq_reg;
    logic                  is_bound_reg;
    logic                  event_valid_reg;
    logic                  scan_done_reg;

    logic                  in_fire;
    logic                  out_free;
    logic                  out_load;
    logic                  out_found;
    logic                  scan_take;
    logic                  in_range;
    logic                  irq_ok;
    logic [PROD_W-1:0]     div_prod;
    logic [PORT_W-1:0]     in_group;
    logic [PORT_W-1:0]     in_base;
    logic [GA_W-1:0]       in_idx;
    logic [BIT_W-1:0]      in_bit;
    logic [BIT_W-1:0]      low_b;
    logic [GA_W-1:0]       low_g;
    logic [MA_W-1:0]       scan_port;
    logic [WORD_BITS-1:0]  bit_sel;
    logic [NUM_GROUPS-1:0] grp_sel;

    logic                  grp_rd_en;
    logic [GA_W-1:0]       grp_rd_addr;
    logic [WORD_BITS-1:0]  grp_rd_pend;
    logic [WORD_BITS-1:0]  grp_rd_mask;
    logic                  grp_wr_en;
    logic [WORD_BITS-1:0]  grp_wr_pend;
    logic [WORD_BITS-1:0]  grp_wr_mask;

    logic                  map_rd_en;
    map_entry_t            map_rd_data;
    logic                  map_wr_en;
    logic [MA_W-1:0]       map_wr_addr;
    map_entry_t            map_wr_data;

    // Handshake
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Split the port into group and bit by reciprocal multiply
    assign div_prod = PROD_W'(port) * PROD_W'(RECIP);
    assign in_group = PORT_W'(div_prod >> DIV_K);
    assign in_base  = PORT_W'(32'(in_group) * WORD_BITS);
    assign in_bit   = BIT_W'(port - in_base);
    assign in_idx   = GA_W'(in_group);
    assign in_range = (32'(port) < USABLE_PORTS);
    assign irq_ok   = (32'(irq_number) < NUM_IRQS);

    // Scan picks
    assign low_b     = lowest_bit(bl_reg);
    assign low_g     = lowest_group(gl_reg);
    assign scan_port = MA_W'(32'(gi_reg) * WORD_BITS + 32'(low_b));
    assign bit_sel   = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_reg;
    assign grp_sel   = {{(NUM_GROUPS-1){1'b0}}, 1'b1} << g_reg;

    // Next-state and memory control
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        sel_next       = sel_reg;
        upcall_next    = upcall_reg;
        gl_next        = gl_reg;
        gi_next        = gi_reg;
        bl_next        = bl_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_load       = 1'b0;
        out_found      = 1'b0;
        scan_take      = 1'b0;
        grp_rd_en      = 1'b0;
        grp_rd_addr    = in_idx;
        grp_wr_en      = 1'b0;
        grp_wr_pend    = grp_rd_pend;
        grp_wr_mask    = grp_rd_mask;
        map_rd_en      = 1'b0;
        map_wr_en      = 1'b0;
        map_wr_addr    = MA_W'(port);
        map_wr_data    = '{bound: 1'b0, irq: '0};

        unique case (state_reg)
            ST_CLEAR:
            begin
                map_wr_en   = 1'b1;
                map_wr_addr = clr_reg;
                if (clr_reg == MA_W'(USABLE_PORTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (req_type)
                        REQ_DISPATCH:
                        begin
                            state_next = ST_SCAN;
                        end
                        REQ_RAISE, REQ_MASK, REQ_UNMASK, REQ_ACK:
                        begin
                            if (in_range)
                            begin
                                grp_rd_en  = 1'b1;
                                state_next = ST_RMW;
                            end
                        end
                        REQ_BIND:
                        begin
                            map_wr_en   = in_range && irq_ok;
                            map_wr_data = '{bound: 1'b1, irq: irq_number};
                        end
                        REQ_UNBIND:
                        begin
                            map_wr_en = in_range;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                // Modify the group row and write it back
                grp_wr_en  = 1'b1;
                state_next = ST_IDLE;
                unique case (req_reg)
                    REQ_RAISE:
                    begin
                        grp_wr_pend = grp_rd_pend | bit_sel;
                        if ((grp_rd_mask & bit_sel) == '0)
                        begin
                            sel_next    = sel_reg | grp_sel;
                            upcall_next = 1'b1;
                        end
                    end
                    REQ_MASK:
                    begin
                        grp_wr_mask = grp_rd_mask | bit_sel;
                    end
                    REQ_UNMASK:
                    begin
                        grp_wr_mask = grp_rd_mask & ~bit_sel;
                        if ((grp_rd_pend & bit_sel) != '0)
                        begin
                            sel_next    = sel_reg | grp_sel;
                            upcall_next = 1'b1;
                        end
                    end
                    REQ_ACK:
                    begin
                        grp_wr_mask = grp_rd_mask | bit_sel;
                        grp_wr_pend = grp_rd_pend & ~bit_sel;
                    end
                    default:
                    begin
                        grp_wr_en = 1'b0;
                    end
                endcase
            end
            ST_SCAN:
            begin
                priority if (bl_reg != '0)
                begin
                    // Take the lowest port of the snapshot, fetch its IRQ
                    map_rd_en  = 1'b1;
                    scan_take  = 1'b1;
                    bl_next    = bl_reg & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << low_b);
                    state_next = ST_MAPRD;
                end
                else if (gl_reg != '0)
                begin
                    // Advance to the next remaining group
                    gl_next     = gl_reg & ~({{(NUM_GROUPS-1){1'b0}}, 1'b1} << low_g);
                    gi_next     = low_g;
                    grp_rd_en   = 1'b1;
                    grp_rd_addr = low_g;
                    state_next  = ST_LOAD;
                end
                else if (upcall_reg)
                begin
                    upcall_next = 1'b0;
                    gl_next     = sel_reg;
                    sel_next    = '0;
                end
                else
                begin
                    // Report the scan done once the output register is free
                    if (out_free)
                    begin
                        out_load       = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_LOAD:
            begin
                bl_next    = grp_rd_pend & ~grp_rd_mask;
                state_next = ST_SCAN;
            end
            ST_MAPRD:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_found      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            sel_reg       <= '0;
            upcall_reg    <= 1'b0;
            gl_reg        <= '0;
            gi_reg        <= '0;
            bl_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sel_reg       <= sel_next;
            upcall_reg    <= upcall_next;
            gl_reg        <= gl_next;
            gi_reg        <= gi_next;
            bl_reg        <= bl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req_type;
            g_reg   <= in_idx;
            bit_reg <= in_bit;
        end
        if (scan_take)
        begin
            scan_port_reg <= scan_port;
        end
        if (out_load)
        begin
            event_port_reg  <= out_found ? PORT_W'(scan_port_reg) : '0;
            event_irq_reg   <= (out_found && map_rd_data.bound) ? map_rd_data.irq : '0;
            is_bound_reg    <= out_found && map_rd_data.bound;
            event_valid_reg <= out_found;
            scan_done_reg   <= !out_found;
        end
    end

    assign event_port  = event_port_reg;
    assign event_irq   = event_irq_reg;
    assign is_bound    = is_bound_reg;
    assign event_valid = event_valid_reg;
    assign scan_done   = scan_done_reg;

    tled_grp_mem #(
        .WORD_BITS  (WORD_BITS),
        .NUM_GROUPS (NUM_GROUPS)
    ) u_grp_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (grp_rd_en),
        .rd_addr (grp_rd_addr),
        .rd_pend (grp_rd_pend),
        .rd_mask (grp_rd_mask),
        .wr_en   (grp_wr_en),
        .wr_addr (g_reg),
        .wr_pend (grp_wr_pend),
        .wr_mask (grp_wr_mask)
    );

    tled_map_mem #(
        .DEPTH (USABLE_PORTS)
    ) u_map_mem (
        .clk     (clk),
        .rd_en   (map_rd_en),
        .rd_addr (scan_port),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data)
    );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the two-level event dispatch unit.
module testbench;
    import tled_pkg::*;

    localparam int WORD_BITS    = 32;
    localparam int NUM_PORTS    = 1024;
    localparam int NUM_IRQS     = 256;
    localparam int NUM_GROUPS   = (NUM_PORTS / WORD_BITS < WORD_BITS) ?
                                  NUM_PORTS / WORD_BITS : WORD_BITS;
    localparam int USABLE_PORTS = NUM_GROUPS * WORD_BITS;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;

    // Request code with no defined operation
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [PORT_W-1:0] port;
        logic [IRQ_W-1:0]  irq;
    } request_t;

    typedef struct packed {
        logic [PORT_W-1:0] event_port;
        logic [IRQ_W-1:0]  event_irq;
        logic              is_bound;
        logic              event_valid;
        logic              scan_done;
    } dispatch_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [REQ_W-1:0]  req_type = '0;
    logic [PORT_W-1:0] port = '0;
    logic [IRQ_W-1:0]  irq_number = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [PORT_W-1:0] event_port;
    logic [IRQ_W-1:0]  event_irq;
    logic              is_bound;
    logic              event_valid;
    logic              scan_done;

    // Predicted dispatcher state
    logic [WORD_BITS-1:0] pend_w [NUM_GROUPS];
    logic [WORD_BITS-1:0] mask_w [NUM_GROUPS];
    logic [WORD_BITS-1:0] group_sel;
    logic                 upcall;
    map_entry_t           irq_map [USABLE_PORTS];
    logic [WORD_BITS-1:0] scan_groups;
    int                   scan_group;
    logic [WORD_BITS-1:0] scan_bits;

    request_t         request_q [$];
    dispatch_result_t dispatch_expect_q [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_asks = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    logic in_taken = 1'b0;
    int  queued_cnt = 0;
    int  accepted_cnt = 0;
    int  mismatches = 0;
    int  stall_cycles = 0;
    int  found_bound = 0;
    int  found_unbound = 0;
    int  done_results = 0;

    two_level_event_dispatch_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .port        (port),
        .irq_number  (irq_number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_port  (event_port),
        .event_irq   (event_irq),
        .is_bound    (is_bound),
        .event_valid (event_valid),
        .scan_done   (scan_done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int lowest_set(input logic [WORD_BITS-1:0] v);
        int i;
        for (i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
                lowest_set = i;
        end
        if (v == '0)
            lowest_set = 0;
    endfunction

    // Update predicted state for one accepted request; queue a result for a dispatch
    task automatic apply_request(input logic [REQ_W-1:0] req, input logic [PORT_W-1:0] p,
                                 input logic [IRQ_W-1:0] irq);
        int               g;
        int               b;
        int               steps;
        int               bi;
        int               ng;
        logic             searching;
        logic [PORT_W-1:0] fp;
        map_entry_t       m;
        dispatch_result_t res;
        g = int'(p) / WORD_BITS;
        b = int'(p) % WORD_BITS;
        if (req == REQ_DISPATCH)
        begin
            res = '0;
            res.scan_done = 1'b1;
            searching = 1'b1;
            for (steps = 0; steps < 2 * WORD_BITS + 4 && searching; steps++)
            begin
                if (scan_bits != '0)
                begin
                    // take the lowest port left in the snapshot
                    bi = lowest_set(scan_bits);
                    fp = PORT_W'(scan_group * WORD_BITS + bi);
                    scan_bits[bi] = 1'b0;
                    m = irq_map[fp];
                    res.event_port  = fp;
                    res.event_irq   = m.bound ? m.irq : '0;
                    res.is_bound    = m.bound;
                    res.event_valid = 1'b1;
                    res.scan_done   = 1'b0;
                    searching = 1'b0;
                end
                else if (scan_groups != '0)
                begin
                    // load the next group snapshot, empty ones fall through
                    ng = lowest_set(scan_groups);
                    scan_groups[ng] = 1'b0;
                    scan_group = ng;
                    scan_bits = (ng < NUM_GROUPS) ? (pend_w[ng] & ~mask_w[ng]) : '0;
                end
                else if (upcall)
                begin
                    upcall = 1'b0;
                    scan_groups = group_sel;
                    group_sel = '0;
                end
                else
                begin
                    searching = 1'b0;
                end
            end
            dispatch_expect_q.push_back(res);
        end
        else if (int'(p) < USABLE_PORTS)
        begin
            case (req)
                REQ_RAISE:
                begin
                    pend_w[g][b] = 1'b1;
                    if (!mask_w[g][b])
                    begin
                        group_sel[g] = 1'b1;
                        upcall = 1'b1;
                    end
                end
                REQ_MASK:
                    mask_w[g][b] = 1'b1;
                REQ_UNMASK:
                begin
                    mask_w[g][b] = 1'b0;
                    if (pend_w[g][b])
                    begin
                        group_sel[g] = 1'b1;
                        upcall = 1'b1;
                    end
                end
                REQ_ACK:
                begin
                    mask_w[g][b] = 1'b1;
                    pend_w[g][b] = 1'b0;
                end
                REQ_BIND:
                begin
                    if (int'(irq) < NUM_IRQS)
                    begin
                        irq_map[p].bound = 1'b1;
                        irq_map[p].irq   = irq;
                    end
                end
                REQ_UNBIND:
                    irq_map[p] = '0;
                default:
                    ;
            endcase
        end
    endtask

    task automatic queue_request(input logic [REQ_W-1:0] req, input logic [PORT_W-1:0] p,
                                 input logic [IRQ_W-1:0] irq);
        request_t r;
        r.req  = req;
        r.port = p;
        r.irq  = irq;
        request_q.push_back(r);
        queued_cnt++;
    endtask

    // Bring a few ports live, then walk the scan with some disturbance
    task automatic queue_scan_burst();
        int                n;
        int                g0;
        int                k;
        logic [PORT_W-1:0] p;
        logic [PORT_W-1:0] live [$];
        n  = $urandom_range(1, 6);
        g0 = $urandom_range(0, NUM_GROUPS - 1);
        for (k = 0; k < n; k++)
        begin
            p[PORT_W-1:5] = 5'((g0 + $urandom_range(0, 2)) % NUM_GROUPS);
            case ($urandom_range(0, 3))
                0: p[4:0] = 5'd0;
                1: p[4:0] = 5'd31;
                default: p[4:0] = 5'($urandom);
            endcase
            live.push_back(p);
            if ($urandom_range(0, 1))
                queue_request(REQ_BIND, p, IRQ_W'($urandom));
            else if ($urandom_range(0, 3) == 0)
                queue_request(REQ_UNBIND, p, IRQ_W'($urandom));
            if ($urandom_range(0, 1))
            begin
                queue_request(REQ_RAISE, p, IRQ_W'($urandom));
                queue_request(REQ_UNMASK, p, IRQ_W'($urandom));
            end
            else
            begin
                queue_request(REQ_UNMASK, p, IRQ_W'($urandom));
                queue_request(REQ_RAISE, p, IRQ_W'($urandom));
            end
        end
        for (k = 0; k < n + 2; k++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                p = live[$urandom_range(0, live.size() - 1)];
                case ($urandom_range(0, 3))
                    0: queue_request(REQ_MASK, p, IRQ_W'($urandom));
                    1: queue_request(REQ_ACK, p, IRQ_W'($urandom));
                    2: queue_request(REQ_UNMASK, p, IRQ_W'($urandom));
                    default: queue_request(REQ_RAISE, p, IRQ_W'($urandom));
                endcase
            end
            queue_request(REQ_DISPATCH, PORT_W'($urandom), IRQ_W'($urandom));
        end
        // acknowledge most of the ports, as a handler would
        foreach (live[k])
        begin
            if ($urandom_range(0, 9) < 7)
                queue_request(REQ_ACK, live[k], IRQ_W'($urandom));
        end
    endtask

    task automatic queue_random_phase(input int target);
        int start;
        int k;
        start = queued_cnt;
        while (queued_cnt - start < target)
        begin
            if ($urandom_range(0, 3) != 0)
                queue_scan_burst();
            else
            begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                    queue_request(REQ_W'($urandom), PORT_W'($urandom), IRQ_W'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_cnt != queued_cnt || dispatch_expect_q.size() != 0);
        @(posedge clk);
    endtask

    // Drive requests from the pending queue at the falling edge
    always @(negedge clk)
    begin
        request_t r;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                r = request_q.pop_front();
                in_valid   <= 1'b1;
                req_type   <= r.req;
                port       <= r.port;
                irq_number <= r.irq;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Drive the result-side ready, with a long hold-off when one is asked for
    always @(negedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Sample transfers at the rising edge: predict on input, check on output
    always @(posedge clk)
    begin
        dispatch_result_t got;
        dispatch_result_t exp_res;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                accepted_cnt++;
                apply_request(req_type, port, irq_number);
            end
            if (out_valid && out_ready)
            begin
                got = {event_port, event_irq, is_bound, event_valid, scan_done};
                if (dispatch_expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: port=%0d irq=%0d",
                                 $time, event_port, event_irq);
                end
                else
                begin
                    exp_res = dispatch_expect_q.pop_front();
                    if (exp_res.event_valid && exp_res.is_bound)
                        found_bound++;
                    else if (exp_res.event_valid)
                        found_unbound++;
                    else
                        done_results++;
                    if (got.event_port !== exp_res.event_port ||
                        got.event_irq !== exp_res.event_irq ||
                        got.is_bound !== exp_res.is_bound ||
                        got.event_valid !== exp_res.event_valid ||
                        got.scan_done !== exp_res.scan_done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch, expected port=%0d irq=%0d bound=%0b",
                                     $time, exp_res.event_port, exp_res.event_irq,
                                     exp_res.is_bound);
                            $display("    expected valid=%0b done=%0b, got port=%0d irq=%0d",
                                     exp_res.event_valid, exp_res.scan_done,
                                     got.event_port, got.event_irq);
                            $display("    got bound=%0b valid=%0b done=%0b",
                                     got.is_bound, got.event_valid, got.scan_done);
                        end
                    end
                end
            end
        end
    end

    // Stop the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int i;
        int directed_cnt;
        for (i = 0; i < NUM_GROUPS; i++)
        begin
            pend_w[i] = '0;
            mask_w[i] = '1;
        end
        for (i = 0; i < USABLE_PORTS; i++)
            irq_map[i] = '0;
        group_sel   = '0;
        upcall      = 1'b0;
        scan_groups = '0;
        scan_group  = 0;
        scan_bits   = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every request, rebind, mask after snapshot, unknown code
        send_idle_pct = 37;
        recv_idle_pct = 69;
        queue_request(REQ_DISPATCH, 10'd0, 8'd0);
        queue_request(REQ_RAISE, 10'd0, 8'd0);
        queue_request(REQ_DISPATCH, 10'd1023, 8'd255);
        queue_request(REQ_BIND, 10'd0, 8'd255);
        queue_request(REQ_UNMASK, 10'd0, 8'd0);
        queue_request(REQ_UNMASK, 10'd1023, 8'd0);
        queue_request(REQ_RAISE, 10'd1023, 8'd255);
        queue_request(REQ_BIND, 10'd1023, 8'd0);
        queue_request(REQ_UNMASK, 10'd31, 8'd0);
        queue_request(REQ_RAISE, 10'd31, 8'd0);
        queue_request(REQ_BIND, 10'd31, 8'd7);
        queue_request(REQ_BIND, 10'd31, 8'd200);
        queue_request(REQ_UNKNOWN, 10'd1023, 8'd255);
        queue_request(REQ_DISPATCH, 10'd0, 8'd0);
        queue_request(REQ_DISPATCH, 10'd0, 8'd0);
        queue_request(REQ_UNBIND, 10'd1023, 8'd0);
        queue_request(REQ_DISPATCH, 10'd0, 8'd0);
        queue_request(REQ_DISPATCH, 10'd0, 8'd0);
        queue_request(REQ_UNMASK, 10'd32, 8'd0);
        queue_request(REQ_UNMASK, 10'd33, 8'd0);
        queue_request(REQ_RAISE, 10'd32, 8'd0);
        queue_request(REQ_RAISE, 10'd33, 8'd0);
        queue_request(REQ_DISPATCH, 10'd0, 8'd0);
        queue_request(REQ_MASK, 10'd33, 8'd0);
        queue_request(REQ_DISPATCH, 10'd0, 8'd0);
        queue_request(REQ_DISPATCH, 10'd0, 8'd0);
        queue_request(REQ_ACK, 10'd32, 8'd0);
        directed_cnt = queued_cnt;

        // Random phase with a busy receiver
        queue_random_phase(280);
        wait_drained();

        // Swap idling, start with a long receiver hold-off to fill the block
        send_idle_pct = 69;
        recv_idle_pct = 37;
        hold_asks++;
        for (i = 0; i < 12; i++)
            queue_request(REQ_DISPATCH, PORT_W'($urandom), IRQ_W'($urandom));
        queue_random_phase(270);
        wait_drained();

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_phase(270);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d requests (%0d directed) over three idling phases and one hold-off.",
                 accepted_cnt, directed_cnt);
        $display("Dispatch results: %0d bound events, %0d unbound events, %0d scan done.",
                 found_bound, found_unbound, done_results);
        if (mismatches == 0 && dispatch_expect_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/tled_pkg.sv
design/tled_grp_mem.sv
design/tled_map_mem.sv
design/two_level_event_dispatch_unit.sv
dv/testbench.sv
